>>> rtl/mshash_pkg.sv
// ----------------------------------------------------------------------------
// mshash_pkg
// shared types and constants of the 64-bit byte-stream hash core
// ----------------------------------------------------------------------------
package mshash_pkg;

  localparam int WORD_W      = 64;
  localparam int CNT_W       = 4;
  localparam int IN_TDATA_W  = 72;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] FULL_CNT = 4'd8;

  localparam logic [63:0] KEY_MUL   = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] HASH_ADD  = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] FIN_MUL_A = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_MUL_B = 64'hc4ce_b9fe_1a85_ec53;

  localparam int KEY_ROT  = 31;
  localparam int HASH_ROT = 27;
  localparam int FIN_SHR  = 33;

  // one classified request on its way from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;   // already masked to its valid bytes
    logic [CNT_W-1:0]  cnt;    // saturated byte count, 0..8
    logic              full;   // eight valid bytes
    logic              fin;    // ends the message
  } item_t;

  typedef struct packed {
    logic idle;   // back end waits for a request
    logic emit;   // back end loads a result this cycle
  } back_stat_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

endpackage

>>> rtl/mshash_front.sv
// ----------------------------------------------------------------------------
// mshash_front
// accepts input requests, saturates the count, masks tail bytes, drops empty non-final words
// ----------------------------------------------------------------------------
module mshash_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mshash_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                                in_tlast,
  input  logic                                q_full,
  output logic                                q_push,
  output mshash_pkg::item_t                   q_item
);

  logic [mshash_pkg::WORD_W-1:0] word;
  logic [mshash_pkg::CNT_W-1:0]  cnt_raw;
  logic [mshash_pkg::CNT_W-1:0]  cnt;
  logic [mshash_pkg::WORD_W-1:0] masked;
  logic                          drop;

  assign word    = in_tdata[mshash_pkg::WORD_W-1:0];
  assign cnt_raw = in_tdata[mshash_pkg::WORD_W +: mshash_pkg::CNT_W];
  assign cnt     = (cnt_raw > mshash_pkg::FULL_CNT) ? mshash_pkg::FULL_CNT : cnt_raw;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < cnt) ? word[8*i +: 8] : 8'h00;
    end
  end

  // an empty word that does not end the message changes nothing
  assign drop      = (cnt == '0) && !in_tlast;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && !drop;

  assign q_item.word = masked;
  assign q_item.cnt  = cnt;
  assign q_item.full = (cnt == mshash_pkg::FULL_CNT);
  assign q_item.fin  = in_tlast || (cnt != mshash_pkg::FULL_CNT);

endmodule

>>> rtl/mshash_fifo.sv
// ----------------------------------------------------------------------------
// mshash_fifo
// short request queue between front and back end
// ----------------------------------------------------------------------------
module mshash_fifo #(
  parameter int DEPTH = mshash_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mshash_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output mshash_pkg::item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mshash_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/mshash_back.sv
// ----------------------------------------------------------------------------
// mshash_back
// mixing sequencer: one shared 32x32 multiplier builds each 64-bit product
// ----------------------------------------------------------------------------
module mshash_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mshash_pkg::WORD_W-1:0] cfg_wdata,
  input  logic                          q_valid,
  input  mshash_pkg::item_t             q_item,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mshash_pkg::WORD_W-1:0] out_tdata,
  output mshash_pkg::back_stat_t        stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KMUL = 3'd1;
  localparam logic [2:0] S_KMIX = 3'd2;
  localparam logic [2:0] S_FIN0 = 3'd3;
  localparam logic [2:0] S_FMA  = 3'd4;
  localparam logic [2:0] S_FIN1 = 3'd5;
  localparam logic [2:0] S_FMB  = 3'd6;
  localparam logic [2:0] S_FIN2 = 3'd7;

  logic [2:0]  st_r, st_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] tot_r, tot_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] p_r;
  logic        full_r, full_nxt;
  logic        fin_r, fin_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] hash_r, hash_nxt;

  logic [63:0] mul_k;
  logic [31:0] m_a, m_b;
  logic [63:0] m_p;
  logic        mul_st;
  logic [63:0] k_rot, t_rot, h_fin, acc_shr;
  logic        emit;

  assign mul_st = (st_r == S_KMUL) || (st_r == S_FMA) || (st_r == S_FMB);

  always_comb begin
    unique case (st_r)
      S_KMUL:  mul_k = mshash_pkg::KEY_MUL;
      S_FMA:   mul_k = mshash_pkg::FIN_MUL_A;
      default: mul_k = mshash_pkg::FIN_MUL_B;
    endcase
  end

  // low 64 bits of x*k: lo*lo, then the low halves of both cross terms
  always_comb begin
    unique case (ph_r)
      2'd1:    begin m_a = x_r[31:0];  m_b = mul_k[63:32]; end
      2'd2:    begin m_a = x_r[63:32]; m_b = mul_k[31:0];  end
      default: begin m_a = x_r[31:0];  m_b = mul_k[31:0];  end
    endcase
  end
  assign m_p = {32'b0, m_a} * {32'b0, m_b};

  always_ff @(posedge clk) begin
    p_r <= m_p;
  end

  assign k_rot   = mshash_pkg::rotl64(acc_r, mshash_pkg::KEY_ROT);
  assign t_rot   = mshash_pkg::rotl64(h_r ^ k_rot, mshash_pkg::HASH_ROT);
  assign h_fin   = h_r ^ tot_r;
  assign acc_shr = acc_r ^ (acc_r >> mshash_pkg::FIN_SHR);
  assign emit    = (st_r == S_FIN2) && (!ov_r || out_tready);

  assign q_pop = (st_r == S_IDLE) && q_valid;

  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    seed_nxt = seed_r;
    h_nxt    = h_r;
    tot_nxt  = tot_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    full_nxt = full_r;
    fin_nxt  = fin_r;
    hash_nxt = hash_r;
    ov_nxt   = ov_r && !out_tready;

    if (mul_st) begin
      ph_nxt = ph_r + 2'd1;
      unique case (ph_r)
        2'd0: acc_nxt = acc_r;
        2'd1: acc_nxt = p_r;
        default: acc_nxt = {acc_r[63:32] + p_r[31:0], acc_r[31:0]};
      endcase
    end

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          x_nxt    = q_item.word;
          full_nxt = q_item.full;
          fin_nxt  = q_item.fin;
          tot_nxt  = tot_r + {60'b0, q_item.cnt};
          ph_nxt   = 2'd0;
          // an empty final word goes straight to the finalizer
          st_nxt   = (q_item.cnt == '0) ? S_FIN0 : S_KMUL;
        end
      end
      S_KMUL: if (ph_r == 2'd3) st_nxt = S_KMIX;
      S_KMIX: begin
        if (full_r) begin
          h_nxt = (t_rot << 2) + t_rot + mshash_pkg::HASH_ADD;
        end else begin
          h_nxt = h_r ^ k_rot;
        end
        st_nxt = fin_r ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        x_nxt   = h_fin ^ (h_fin >> mshash_pkg::FIN_SHR);
        h_nxt   = seed_r;
        tot_nxt = '0;
        ph_nxt  = 2'd0;
        st_nxt  = S_FMA;
      end
      S_FMA: if (ph_r == 2'd3) st_nxt = S_FIN1;
      S_FIN1: begin
        x_nxt  = acc_shr;
        ph_nxt = 2'd0;
        st_nxt = S_FMB;
      end
      S_FMB: if (ph_r == 2'd3) st_nxt = S_FIN2;
      S_FIN2: begin
        if (emit) begin
          hash_nxt = acc_shr;
          ov_nxt   = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      seed_nxt = cfg_wdata;
      h_nxt    = cfg_wdata;
      tot_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ph_r   <= 2'd0;
      seed_r <= '0;
      h_r    <= '0;
      tot_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      seed_r <= seed_nxt;
      h_r    <= h_nxt;
      tot_r  <= tot_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    full_r <= full_nxt;
    fin_r  <= fin_nxt;
    hash_r <= hash_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = hash_r;
  assign stat.idle  = (st_r == S_IDLE);
  assign stat.emit  = emit;

endmodule

>>> rtl/murmur_style_64bit_byte_hash_core.sv
// ----------------------------------------------------------------------------
// murmur_style_64bit_byte_hash_core
// 64-bit byte-stream hash, murmur-style word mixing with fmix64 finalizer
// ----------------------------------------------------------------------------
// A message arrives as little-endian 64-bit words with a byte count and tlast;
// a short count ends the message. The front end accepts a request every cycle
// while its small queue has room; the back end runs all mixing through a
// single 32x32 multiplier that builds each 64-bit product from its partial
// products in turn. Each word is multiplied by the key and mixed into the
// running hash; the message end then runs the finalizer with two further
// products. The result is held in an output register, so the next message
// is already mixed while a hash waits. Writing the seed reloads the running
// hash and clears the byte total.
module murmur_style_64bit_byte_hash_core #(
  parameter int QUEUE_DEPTH = mshash_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mshash_pkg::WORD_W-1:0]     cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mshash_pkg::IN_TDATA_W-1:0] in_tdata,   // data_word, byte_count, zero pad
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mshash_pkg::WORD_W-1:0]     out_tdata   // hash
);

  logic                   q_push, q_full, q_pop, q_valid;
  mshash_pkg::item_t      q_in_item, q_out_item;
  mshash_pkg::back_stat_t bk_stat;

  mshash_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  mshash_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_out_item)
  );

  mshash_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_out_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (bk_stat)
  );

  // a request is never written into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request pushed into full queue");

  // the back end only takes a request when it is idle and one is queued
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && bk_stat.idle))
    else $error("request popped while back end busy or queue empty");

  // a finished hash shows up on the output the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.emit |=> (out_tvalid && bk_stat.idle))
    else $error("finished hash not presented");

endmodule

>>> tb/sv/mshash_checker.sv
// ----------------------------------------------------------------------------
// mshash_checker
// watches the hash core's channels, predicts every hash and compares
// ----------------------------------------------------------------------------
// Tracks the seed register and the running message state from the requests
// the core accepts. Each finished message pushes its hash onto a queue, and
// every hash the core hands out is compared with the oldest one there.
// ----------------------------------------------------------------------------
module mshash_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mshash_pkg::WORD_W-1:0]     cfg_wdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [mshash_pkg::IN_TDATA_W-1:0] in_tdata,   // data_word, byte_count, zero pad
  input  logic                              in_tlast,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [mshash_pkg::WORD_W-1:0]     out_tdata,  // hash
  output int                                fail_count,
  output int                                pending,
  output int                                words_seen,
  output int                                hashes_seen
);

  localparam logic [63:0] WORD_MUL  = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] STEP_ADD  = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] AVAL_MUL1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] AVAL_MUL2 = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [3:0]  WORD_BYTES = 4'd8;

  logic [63:0] seed_reg;
  logic [63:0] run_hash;
  logic [63:0] byte_total;
  logic [63:0] expected_hashes[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    words_seen  = 0;
    hashes_seen = 0;
  end

  // word times the key multiplier, then rotated left by 31
  function automatic logic [63:0] scramble_word(input logic [63:0] w);
    logic [63:0] p;
    p = w * WORD_MUL;
    return {p[32:0], p[63:33]};
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] h);
    logic [63:0] x;
    x = h ^ (h >> 33);
    x = x * AVAL_MUL1;
    x = x ^ (x >> 33);
    x = x * AVAL_MUL2;
    return x ^ (x >> 33);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic absorb_word(input logic [63:0] w, input logic [3:0] raw_cnt,
                             input logic lst);
    logic [3:0]  cnt;
    logic [63:0] h;
    logic [63:0] mask;
    logic        ends;
    cnt  = (raw_cnt > WORD_BYTES) ? WORD_BYTES : raw_cnt;
    h    = run_hash;
    ends = lst;
    // an empty word that does not close the message changes nothing
    if (cnt == 4'd0 && !lst) return;
    if (cnt == WORD_BYTES) begin
      h = h ^ scramble_word(w);
      h = {h[36:0], h[63:37]};
      h = h * 64'd5 + STEP_ADD;
    end else if (cnt != 4'd0) begin
      // a short word is always the tail, last mark or not
      mask = (64'd1 << (8 * cnt)) - 64'd1;
      h    = h ^ scramble_word(w & mask);
      ends = 1'b1;
    end
    byte_total = byte_total + 64'(cnt);
    if (!ends) begin
      run_hash = h;
      return;
    end
    expected_hashes.push_back(avalanche(h ^ byte_total));
    run_hash   = seed_reg;
    byte_total = '0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_reg   = '0;
      run_hash   = '0;
      byte_total = '0;
      expected_hashes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        hashes_seen++;
        if (expected_hashes.size() == 0)
          report_mismatch("hash with no message pending", out_tdata, 'x);
        else if (out_tdata !== expected_hashes[0]) begin
          report_mismatch("hash mismatch", out_tdata, expected_hashes[0]);
          void'(expected_hashes.pop_front());
        end else
          void'(expected_hashes.pop_front());
      end
      // a seed write drops any message in progress
      if (cfg_we) begin
        seed_reg   = cfg_wdata;
        run_hash   = cfg_wdata;
        byte_total = '0;
      end
      if (in_tvalid && in_tready) begin
        words_seen++;
        absorb_word(in_tdata[63:0], in_tdata[67:64], in_tlast);
      end
    end
    pending = expected_hashes.size();
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the 64-bit byte-stream hash core
// ----------------------------------------------------------------------------
// Feeds directed corner messages, then random messages of mostly short length
// under several seeds, with random idle bursts on both channels. All checking
// happens in mshash_checker and the core's assertions; this module waits for
// the checker to drain and reports.
module testbench;

  typedef enum int {
    END_FULL,        // full word with last mark
    END_TAIL,        // short word with last mark
    END_EMPTY,       // zero count with last mark
    END_SHORT_OPEN,  // short word without last mark still ends the message
    END_OVERCOUNT,   // count 9..15, treated as eight
    END_NONE         // message left open
  } msg_end_t;

  localparam int ITEM_TARGET = 1300;
  localparam int CALM_AFTER  = 1100;
  localparam int SETTLE_CYC  = 100;

  logic                              clk;
  logic                              rst_n      = 1'b0;
  logic                              cfg_we     = 1'b0;
  logic [mshash_pkg::WORD_W-1:0]     cfg_wdata  = '0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [mshash_pkg::IN_TDATA_W-1:0] in_tdata   = '0;
  logic                              in_tlast   = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [mshash_pkg::WORD_W-1:0]     out_tdata;

  int fail_count, pending, words_seen, hashes_seen;
  int items_sent  = 0;
  int seeds_used  = 0;
  int stall_left  = 0;
  bit no_idle     = 1'b0;

  murmur_style_64bit_byte_hash_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mshash_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .words_seen  (words_seen),
    .hashes_seen (hashes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout: hash core stopped responding");
    $display("*** FAILED ***");
    $finish;
  end

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (!rst_n || no_idle)
      out_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else
      out_tready <= 1'b1;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called and returns at a falling edge; in_tvalid stays high for a follow-up
  task automatic send_word(input logic [63:0] w, input logic [3:0] cnt,
                           input logic lst);
    int gap;
    if (!no_idle && $urandom_range(3) == 0) begin
      gap       = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      in_tdata  <= {8'($urandom), rand64()};
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, cnt, w};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (cnt != 4'd0 || lst) items_sent++;
  endtask

  task automatic write_seed(input logic [63:0] value);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    // words with no hash of their own may still be in the back end
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    seeds_used++;
  endtask

  task automatic send_message(input int n_full, input msg_end_t how);
    logic [3:0] cnt;
    for (int i = 0; i < n_full; i++) begin
      if ($urandom_range(9) == 0) send_word(rand64(), 4'd0, 1'b0);
      cnt = ($urandom_range(7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
      send_word(rand64(), cnt, 1'b0);
    end
    unique case (how)
      END_FULL:       send_word(rand64(), 4'd8, 1'b1);
      END_TAIL:       send_word(rand64(), 4'($urandom_range(1, 7)), 1'b1);
      END_EMPTY:      send_word(rand64(), 4'd0, 1'b1);
      END_SHORT_OPEN: send_word(rand64(), 4'($urandom_range(1, 7)), 1'b0);
      END_OVERCOUNT:  send_word(rand64(), 4'($urandom_range(9, 15)), 1'($urandom));
      default: ;
    endcase
  endtask

  initial begin
    logic [63:0] seeds[6];
    int          n_full;
    int          quota;
    msg_end_t    how;
    seeds = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h8000_0000_0000_0001,
              rand64(), rand64(), rand64()};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners under the reset seed of zero, then under an all-ones seed
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_word(64'h0, 4'd8, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1);
    send_word(64'h0123_4567_89AB_CDEF, 4'd3, 1'b0);
    send_word(64'hDEAD_BEEF_0000_0000, 4'd0, 1'b0);
    send_word(64'h5555_AAAA_5555_AAAA, 4'd15, 1'b1);
    send_word(64'hAAAA_5555_AAAA_5555, 4'd9, 1'b0);
    send_word(64'h1111_2222_3333_4444, 4'd8, 1'b1);
    send_word(64'h8000_0000_0000_0001, 4'd8, 1'b0);
    send_word(64'h7FFF_FFFF_FFFF_FFFE, 4'd8, 1'b0);
    send_word(64'hFEDC_BA98_7654_3210, 4'd8, 1'b0);
    send_word(64'h0, 4'd0, 1'b1);
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 1'b1);

    // random messages, one seed per phase
    quota = 0;
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      quota += ITEM_TARGET / 6;
      while (items_sent < quota + 18) begin
        if (items_sent > CALM_AFTER) no_idle = 1'b1;
        n_full = ($urandom_range(9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
        how    = msg_end_t'($urandom_range(0, 4));
        send_message(n_full, how);
      end
      // leave one message open so the next seed write abandons it
      if (p == 2) send_message(3, END_NONE);
    end
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE_CYC) @(negedge clk);
    $display("covered %0d accepted words and %0d hashes over %0d seed settings",
             words_seen, hashes_seen, seeds_used);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/mshash_pkg.sv
rtl/mshash_front.sv
rtl/mshash_fifo.sv
rtl/mshash_back.sv
rtl/murmur_style_64bit_byte_hash_core.sv
tb/sv/mshash_checker.sv
tb/sv/testbench.sv
